>>> rtl/csf_pkg.sv
// Shared constants, segment fonts and digit helpers for the clock
// seven-segment formatter. Used by the formatter and its stream checker.
// No dependencies.
package csf_pkg;

	// Snapshot and row geometry
	localparam int unsigned ROWS       = 8;
	localparam int unsigned ROW_W      = $clog2(ROWS);
	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned IN_USER_W  = 4;
	localparam int unsigned OUT_DATA_W = 32;
	localparam int unsigned BRIGHT_W   = 4;

	// Display mode codes
	localparam logic [3:0] MODE_INT_TEMP  = 4'd0;
	localparam logic [3:0] MODE_EXT_TEMP  = 4'd1;
	localparam logic [3:0] MODE_SET_HOUR  = 4'd2;
	localparam logic [3:0] MODE_SET_MIN   = 4'd3;
	localparam logic [3:0] MODE_SET_SEC   = 4'd4;
	localparam logic [3:0] MODE_SET_DATE  = 4'd5;
	localparam logic [3:0] MODE_SET_MONTH = 4'd6;
	localparam logic [3:0] MODE_SET_YEAR  = 4'd7;
	localparam logic [3:0] MODE_INTENSITY = 4'd8;
	localparam logic [3:0] MODE_DEMO      = 4'd9;

	// Segment patterns
	localparam logic [6:0] SAT_MAX = 7'd99;
	localparam logic [7:0] T_COLON = 8'h60;
	localparam logic [7:0] T_DOT   = 8'h80;
	localparam logic [7:0] D_DOT   = 8'h20;
	localparam logic [7:0] D_MINUS = 8'h04;
	localparam logic [7:0] D_DEG   = 8'h0F;
	localparam logic [7:0] D_CEL   = 8'h99;
	localparam logic [7:0] T_E     = 8'h4F;
	localparam logic [7:0] T_R     = 8'h05;
	localparam logic [7:0] T_O     = 8'h1D;

	typedef logic [7:0] seg_t;
	typedef seg_t [ROWS-1:0] row_bytes_t;

	// Time display font, pabcdefg layout
	function automatic seg_t time_glyph(input logic [3:0] d);
		seg_t g;
		unique case (d)
			4'd0:    g = 8'h7E;
			4'd1:    g = 8'h30;
			4'd2:    g = 8'h6D;
			4'd3:    g = 8'h79;
			4'd4:    g = 8'h33;
			4'd5:    g = 8'h5B;
			4'd6:    g = 8'h5F;
			4'd7:    g = 8'h70;
			4'd8:    g = 8'h7F;
			4'd9:    g = 8'h7B;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

	// Date and temperature display font, dcpefgba layout
	function automatic seg_t date_glyph(input logic [3:0] d);
		seg_t g;
		unique case (d)
			4'd0:    g = 8'hDB;
			4'd1:    g = 8'h42;
			4'd2:    g = 8'h97;
			4'd3:    g = 8'hC7;
			4'd4:    g = 8'h4E;
			4'd5:    g = 8'hCD;
			4'd6:    g = 8'hDD;
			4'd7:    g = 8'h43;
			4'd8:    g = 8'hDF;
			4'd9:    g = 8'hCF;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

	// Saturates a value to 99 and returns {tens byte, ones byte}. The tens
	// digit comes from a multiply by 205 and shift by 11, exact below 180.
	function automatic logic [15:0] digit_pair(input logic [7:0] v, input logic blank_lead,
		input logic date_font);
		logic [6:0]  s;
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		seg_t        hi;
		seg_t        lo;
		s    = (v > {1'b0, SAT_MAX}) ? SAT_MAX : v[6:0];
		prod = 15'(s) * 15'd205;
		tens = prod[14:11];
		ones = s - 7'(tens) * 7'd10;
		hi   = date_font ? date_glyph(tens) : time_glyph(tens);
		lo   = date_font ? date_glyph(ones[3:0]) : time_glyph(ones[3:0]);
		if (blank_lead && (tens == 4'd0)) begin
			hi = 8'h00;
		end
		return {hi, lo};
	endfunction

endpackage

>>> rtl/clock_seven_segment_formatter.sv
// Clock seven-segment formatter: turns one clock snapshot into eight
// display rows of segment bytes. Depends on csf_pkg.
//
// Usage:
//   Input stream (s_axis_*): one transaction is one snapshot of clock data
//   (time, colon flag, date, year, temperature) with the display mode on
//   s_axis_tuser. Output stream (m_axis_*): eight transactions per snapshot,
//   rows with address 1 to 8 in order, m_axis_tlast high on the eighth.
//   The brightness register is written through cfg_wr_en/cfg_wr_data;
//   the user is to write it only while the block is idle, as the block
//   itself does not enforce this. It is used by the intensity view. A
//   snapshot is captured in the snapshot register, and its rows then pass
//   through the output row register. Throughput: one row per cycle while
//   the receiver does not stall; this is set by the single output row
//   register, which the row counter fills with the eight rows of the held
//   snapshot in turn. The next snapshot is taken in the same cycle as the
//   last row is loaded, so snapshots follow each other without a gap.
//   Reset clears the snapshot and output valid flags, the row counter and
//   the brightness (to zero). When the receiver stalls, the output row holds
//   and the held snapshot waits; the input side is ready again as the
//   last row of the held snapshot is loaded into the output register.
module clock_seven_segment_formatter
	import csf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration: brightness register
	input  logic                  cfg_wr_en,
	input  logic [BRIGHT_W-1:0]   cfg_wr_data,
	// Input snapshot stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata, low bit up: hours[6:0], minutes[13:7], seconds[20:14],
	// colon_lit[21], day_of_month[28:22], month_value[35:29], year_low[42:36],
	// temperature[50:43], zero fill[55:51]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: display_mode[3:0]
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	// Output row stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata, low bit up: row_address[3:0], temp_segments[11:4],
	// date_segments[19:12], time_segments[27:20], zero fill[31:28]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// tlast: last_row
	output logic                  m_axis_tlast
);

	logic [BRIGHT_W-1:0]  brightness_q;
	logic                 valid_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [IN_DATA_W-1:0] data_s1;
	logic [IN_USER_W-1:0] mode_s1;
	logic                 load;
	logic                 in_fire;
	logic                 last_sel;

	logic [6:0]  hours, minutes, seconds, day, month, year;
	logic        colon;
	logic [7:0]  temp_raw;
	logic [7:0]  temp_mag;
	logic [15:0] hr_pair, mi_pair, se_pair, dy_pair, mo_pair, yr_pair, tp_pair, br_pair;
	row_bytes_t  tm, dt, tp;
	logic [3:0]  row_addr;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= '0;
		end else if (cfg_wr_en) begin
			brightness_q <= cfg_wr_data;
		end
	end

	// Handshake: the output register takes a row whenever it is free or
	// being emptied; the input opens when idle or as the last row is taken.
	assign last_sel      = (row_s1 == ROW_W'(ROWS - 1));
	assign load          = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || (load && last_sel);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Snapshot register and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			row_s1   <= '0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
			row_s1   <= '0;
		end else if (load) begin
			row_s1 <= row_s1 + ROW_W'(1);
			if (last_sel) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= s_axis_tdata;
			mode_s1 <= s_axis_tuser;
		end
	end

	// Field unpacking
	assign hours    = data_s1[6:0];
	assign minutes  = data_s1[13:7];
	assign seconds  = data_s1[20:14];
	assign colon    = data_s1[21];
	assign day      = data_s1[28:22];
	assign month    = data_s1[35:29];
	assign year     = data_s1[42:36];
	assign temp_raw = data_s1[50:43];
	assign temp_mag = temp_raw[7] ? (8'd0 - temp_raw) : temp_raw;

	// Digit pairs
	assign hr_pair = digit_pair({1'b0, hours}, 1'b1, 1'b0);
	assign mi_pair = digit_pair({1'b0, minutes}, 1'b0, 1'b0);
	assign se_pair = digit_pair({1'b0, seconds}, 1'b0, 1'b0);
	assign dy_pair = digit_pair({1'b0, day}, 1'b1, 1'b1);
	assign mo_pair = digit_pair({1'b0, month}, 1'b0, 1'b1);
	assign yr_pair = digit_pair({1'b0, year}, 1'b0, 1'b1);
	assign tp_pair = digit_pair(temp_mag, 1'b1, 1'b1);
	assign br_pair = digit_pair(8'(brightness_q) + 8'd1, 1'b1, 1'b1);

	// Row bytes for the three displays, then the mode overrides
	always_comb begin
		tm[0] = hr_pair[15:8];
		tm[1] = hr_pair[7:0];
		tm[2] = colon ? T_COLON : 8'h00;
		tm[3] = mi_pair[15:8];
		tm[4] = mi_pair[7:0];
		tm[5] = colon ? T_COLON : 8'h00;
		tm[6] = se_pair[15:8];
		tm[7] = se_pair[7:0];

		dt[0] = dy_pair[15:8];
		dt[1] = dy_pair[7:0] | D_DOT;
		dt[2] = mo_pair[15:8];
		dt[3] = mo_pair[7:0] | D_DOT;
		dt[4] = date_glyph(4'd2);
		dt[5] = date_glyph(4'd0);
		dt[6] = yr_pair[15:8];
		dt[7] = yr_pair[7:0];

		tp[0] = 8'h00;
		tp[1] = temp_raw[7] ? D_MINUS : 8'h00;
		tp[2] = tp_pair[15:8];
		tp[3] = tp_pair[7:0];
		tp[4] = D_DEG;
		tp[5] = D_CEL;
		tp[6] = 8'h00;
		tp[7] = 8'h00;

		case (mode_s1) inside
			MODE_SET_HOUR, MODE_SET_MIN, MODE_SET_SEC: begin
				tm[2] = 8'h00;
				tm[5] = 8'h00;
				tp    = '0;
				if (mode_s1 == MODE_SET_HOUR) begin
					tm[0] = tm[0] | T_DOT;
					tm[1] = tm[1] | T_DOT;
				end
				if (mode_s1 == MODE_SET_MIN) begin
					tm[3] = tm[3] | T_DOT;
					tm[4] = tm[4] | T_DOT;
				end
				if (mode_s1 == MODE_SET_SEC) begin
					tm[6] = tm[6] | T_DOT;
					tm[7] = tm[7] | T_DOT;
				end
			end
			MODE_SET_DATE, MODE_SET_MONTH, MODE_SET_YEAR: begin
				tm[2] = 8'h00;
				tm[5] = 8'h00;
				tp    = '0;
				for (int k = 0; k < ROWS; k++) begin
					dt[k] = dt[k] & ~D_DOT;
				end
				if (mode_s1 == MODE_SET_DATE) begin
					dt[0] = dt[0] | D_DOT;
					dt[1] = dt[1] | D_DOT;
				end
				if (mode_s1 == MODE_SET_MONTH) begin
					dt[2] = dt[2] | D_DOT;
					dt[3] = dt[3] | D_DOT;
				end
				if (mode_s1 == MODE_SET_YEAR) begin
					dt[4] = dt[4] | D_DOT;
					dt[5] = dt[5] | D_DOT;
					dt[6] = dt[6] | D_DOT;
					dt[7] = dt[7] | D_DOT;
				end
			end
			MODE_INTENSITY: begin
				tp    = '0;
				tp[1] = D_MINUS;
				tp[4] = D_MINUS;
				tp[2] = br_pair[15:8];
				tp[3] = br_pair[7:0];
			end
			MODE_DEMO: begin
				tm[0] = T_E;
				tm[1] = T_R;
				tm[3] = T_R;
				tm[4] = T_O;
				tm[6] = T_R;
				tm[7] = T_R;
			end
			default: begin
				// Plain temperature views and unused codes: no changes
			end
		endcase
	end

	assign row_addr = 4'(row_s1) + 4'd1;

	// Output row register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_axis_tdata <= {4'h0, tm[row_s1], dt[row_s1], tp[row_s1], row_addr};
			m_axis_tlast <= last_sel;
		end
	end

endmodule

>>> rtl/csf_checker.sv
// Port-level checker for the clock seven-segment formatter, with its bind.
// Depends on csf_pkg and the top level clock_seven_segment_formatter.
module csf_checker
	import csf_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast
);

	// A stalled output row holds steady.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output row changed while stalled");

	// The last-row flag marks exactly the row with address eight.
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[3:0] == 4'd8)))
		else $error("last-row flag does not match row address");

	// Row addresses stay between one and eight.
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[3:0] != 4'd0) && (m_axis_tdata[3:0] <= 4'd8))
		else $error("row address out of range");

	// Within a snapshot the next row follows in the very next cycle.
	a_row_next: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast
		|=> m_axis_tvalid && (m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1))
		else $error("rows of a snapshot not contiguous");

	// While a non-last row stalls at the output, no new snapshot is taken.
	a_no_early_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
		else $error("input accepted while a snapshot is still pending");

endmodule

bind clock_seven_segment_formatter csf_checker u_csf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
